/* rtl/slcl_pkg.sv */
// Shared constants and types for the single-layer coverage length block.
package slcl_pkg;

	localparam int MAX_SEGMENTS_DEF = 1024;
	localparam int COORD_BITS_DEF   = 30;
	localparam int IN_COORD_BITS    = 30;
	localparam int LEN_BITS         = 30;

	// Commands from the controller to the datapath.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_STORE_L,
		OP_STORE_R,
		OP_DROP,
		OP_SORT_INIT,
		OP_PASS_START,
		OP_SEG_START,
		OP_ELEM_READ,
		OP_ELEM_WRITE,
		OP_SEG_END,
		OP_PASS_END,
		OP_SWEEP_INIT,
		OP_SWEEP_READ,
		OP_SWEEP_ACC,
		OP_FINISH
	} dp_op_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic fits;
		logic sort_done;
		logic pass_done;
		logic seg_done;
		logic none_stored;
		logic sweep_last;
		logic out_busy;
	} dp_status_t;

endpackage

/* rtl/slcl_if.sv */
// Valid/ready channel interfaces for segment input and result output.
interface slcl_seg_if import slcl_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic                     has_segment;
	logic [IN_COORD_BITS-1:0] left_end;
	logic [IN_COORD_BITS-1:0] right_end;
	logic                     last_segment;

	modport source (output valid, has_segment, left_end, right_end, last_segment, input ready);
	modport sink (input valid, has_segment, left_end, right_end, last_segment, output ready);
endinterface

interface slcl_res_if import slcl_pkg::*;;
	logic                valid;
	logic                ready;
	logic [LEN_BITS-1:0] single_layer_length;
	logic                overflowed;

	modport source (output valid, single_layer_length, overflowed, input ready);
	modport sink (input valid, single_layer_length, overflowed, output ready);
endinterface

/* rtl/slcl_datapath.sv */
// Datapath: endpoint memories, merge sort indexes, sweep accumulator and result register.
module slcl_datapath import slcl_pkg::*; #(
	parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
	parameter int COORD_BITS   = COORD_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  dp_op_t                   op,
	input  logic [IN_COORD_BITS-1:0] left_end,
	input  logic [IN_COORD_BITS-1:0] right_end,
	input  logic                     out_ready,
	output dp_status_t               status,
	output logic                     out_valid,
	output logic [LEN_BITS-1:0]      single_layer_length,
	output logic                     overflowed
);

	localparam int DEPTH = 2 * MAX_SEGMENTS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int EW    = COORD_BITS + 1;
	localparam int DW    = CW + 1;

	logic [EW-1:0] mem0 [DEPTH];
	logic [EW-1:0] mem1 [DEPTH];

	logic [CW-1:0]         count_q;
	logic                  ovf_q;
	logic [CW:0]           width_q;
	logic [CW-1:0]         lo_q, mid_q, hi_q, a_q, b_q, k_q, i_q;
	logic                  bank_q;
	logic [LEN_BITS-1:0]   sum_q;
	logic signed [DW-1:0]  depth_q;
	logic                  out_valid_q;
	logic [COORD_BITS-1:0] right_q, prev_q;
	logic [LEN_BITS-1:0]   len_out_q;
	logic                  ovf_out_q;
	logic [EW-1:0]         rd0a_q, rd0b_q, rd1a_q, rd1b_q;

	logic [CW+1:0]   mid_sum, hi_sum;
	logic [CW-1:0]   mid_n, hi_n;
	logic [CW-1:0]   ra, rb;
	logic [EW-1:0]   da, db;
	logic            take_a;
	logic            we, wbank;
	logic [CW-1:0]   waddr;
	logic [EW-1:0]   wdata;
	logic [LEN_BITS-1:0] gap;

	assign mid_sum = (CW+2)'(lo_q) + (CW+2)'(width_q);
	assign hi_sum  = (CW+2)'(lo_q) + ((CW+2)'(width_q) << 1);
	assign mid_n   = (mid_sum > (CW+2)'(count_q)) ? count_q : mid_sum[CW-1:0];
	assign hi_n    = (hi_sum > (CW+2)'(count_q)) ? count_q : hi_sum[CW-1:0];

	assign ra = (op == OP_SWEEP_READ) ? i_q : a_q;
	assign rb = b_q;
	assign da = bank_q ? rd1a_q : rd0a_q;
	assign db = bank_q ? rd1b_q : rd0b_q;

	assign take_a = (a_q < mid_q) &&
		((b_q >= hi_q) || (da[COORD_BITS-1:0] <= db[COORD_BITS-1:0]));

	assign gap = LEN_BITS'(da[COORD_BITS-1:0]) - LEN_BITS'(prev_q);

	always_comb begin
		we    = 1'b0;
		wbank = 1'b0;
		waddr = count_q;
		wdata = {1'b0, COORD_BITS'(left_end)};
		case (op)
			OP_STORE_L: begin
				we = 1'b1;
			end
			OP_STORE_R: begin
				we    = 1'b1;
				waddr = count_q + CW'(1);
				wdata = {1'b1, right_q};
			end
			OP_ELEM_WRITE: begin
				we    = 1'b1;
				wbank = ~bank_q;
				waddr = k_q;
				wdata = take_a ? da : db;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we && !wbank) begin
			mem0[waddr[AW-1:0]] <= wdata;
		end
		if (we && wbank) begin
			mem1[waddr[AW-1:0]] <= wdata;
		end
		rd0a_q <= mem0[ra[AW-1:0]];
		rd0b_q <= mem0[rb[AW-1:0]];
		rd1a_q <= mem1[ra[AW-1:0]];
		rd1b_q <= mem1[rb[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (op == OP_STORE_L) begin
			right_q <= COORD_BITS'(right_end);
		end
		if (op == OP_SWEEP_ACC) begin
			prev_q <= da[COORD_BITS-1:0];
		end
		if (op == OP_FINISH) begin
			len_out_q <= sum_q;
			ovf_out_q <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ovf_q       <= 1'b0;
			width_q     <= '0;
			lo_q        <= '0;
			mid_q       <= '0;
			hi_q        <= '0;
			a_q         <= '0;
			b_q         <= '0;
			k_q         <= '0;
			i_q         <= '0;
			bank_q      <= 1'b0;
			sum_q       <= '0;
			depth_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (op)
				OP_STORE_R: count_q <= count_q + CW'(2);
				OP_DROP: ovf_q <= 1'b1;
				OP_SORT_INIT: begin
					width_q <= (CW+1)'(1);
					bank_q  <= 1'b0;
				end
				OP_PASS_START: lo_q <= '0;
				OP_SEG_START: begin
					mid_q <= mid_n;
					hi_q  <= hi_n;
					a_q   <= lo_q;
					b_q   <= mid_n;
					k_q   <= lo_q;
				end
				OP_ELEM_WRITE: begin
					k_q <= k_q + CW'(1);
					if (take_a) begin
						a_q <= a_q + CW'(1);
					end else begin
						b_q <= b_q + CW'(1);
					end
				end
				OP_SEG_END: lo_q <= hi_q;
				OP_PASS_END: begin
					width_q <= width_q << 1;
					bank_q  <= ~bank_q;
				end
				OP_SWEEP_INIT: begin
					i_q     <= '0;
					sum_q   <= '0;
					depth_q <= '0;
				end
				OP_SWEEP_ACC: begin
					if (depth_q == DW'(1)) begin
						sum_q <= sum_q + gap;
					end
					depth_q <= da[COORD_BITS] ? depth_q - DW'(1) : depth_q + DW'(1);
					i_q     <= i_q + CW'(1);
				end
				OP_FINISH: begin
					out_valid_q <= 1'b1;
					count_q     <= '0;
					ovf_q       <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	assign status.fits        = ((CW+1)'(count_q) + (CW+1)'(2)) <= (CW+1)'(DEPTH);
	assign status.sort_done   = width_q >= (CW+1)'(count_q);
	assign status.pass_done   = lo_q >= count_q;
	assign status.seg_done    = k_q >= hi_q;
	assign status.none_stored = (count_q == '0);
	assign status.sweep_last  = ((CW+1)'(i_q) + (CW+1)'(1)) == (CW+1)'(count_q);
	assign status.out_busy    = out_valid_q;

	assign out_valid           = out_valid_q;
	assign single_layer_length = len_out_q;
	assign overflowed          = ovf_out_q;

endmodule

/* rtl/slcl_ctrl.sv */
// Controller: sequences loading, the merge sort passes, the sweep and the result.
module slcl_ctrl import slcl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       has_segment,
	input  logic       last_segment,
	input  dp_status_t status,
	output logic       in_ready,
	output dp_op_t     op
);

	typedef enum logic [3:0] {
		S_LOAD, S_LOAD2, S_SORT_INIT, S_PASS, S_SEG, S_RD, S_WR,
		S_SW_INIT, S_SW_RD, S_SW_ACC, S_DONE
	} state_t;

	state_t state_q;
	logic   last_q;
	logic   accept;

	assign in_ready = (state_q == S_LOAD);
	assign accept   = in_ready && in_valid;

	always_comb begin
		op = OP_NONE;
		unique case (state_q)
			S_LOAD: begin
				if (accept && has_segment) begin
					op = status.fits ? OP_STORE_L : OP_DROP;
				end
			end
			S_LOAD2:     op = OP_STORE_R;
			S_SORT_INIT: op = OP_SORT_INIT;
			S_PASS:      op = status.sort_done ? OP_NONE : OP_PASS_START;
			S_SEG:       op = status.pass_done ? OP_PASS_END : OP_SEG_START;
			S_RD:        op = status.seg_done ? OP_SEG_END : OP_ELEM_READ;
			S_WR:        op = OP_ELEM_WRITE;
			S_SW_INIT:   op = OP_SWEEP_INIT;
			S_SW_RD:     op = OP_SWEEP_READ;
			S_SW_ACC:    op = OP_SWEEP_ACC;
			S_DONE:      op = status.out_busy ? OP_NONE : OP_FINISH;
			default:     op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			last_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (accept) begin
						last_q <= last_segment;
						if (has_segment && status.fits) begin
							state_q <= S_LOAD2;
						end else if (last_segment) begin
							state_q <= S_SORT_INIT;
						end
					end
				end
				S_LOAD2:     state_q <= last_q ? S_SORT_INIT : S_LOAD;
				S_SORT_INIT: state_q <= S_PASS;
				S_PASS:      state_q <= status.sort_done ? S_SW_INIT : S_SEG;
				S_SEG:       state_q <= status.pass_done ? S_PASS : S_RD;
				S_RD:        state_q <= status.seg_done ? S_SEG : S_WR;
				S_WR:        state_q <= S_RD;
				S_SW_INIT:   state_q <= status.none_stored ? S_DONE : S_SW_RD;
				S_SW_RD:     state_q <= S_SW_ACC;
				S_SW_ACC:    state_q <= status.sweep_last ? S_DONE : S_SW_RD;
				S_DONE: begin
					if (!status.out_busy) begin
						state_q <= S_LOAD;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

endmodule

/* rtl/single_layer_coverage_length.sv */
// Top level of the single-layer coverage length block.
//
//  channel  direction  carries
//  seg      in         has_segment, left_end, right_end, last_segment
//  res      out        single_layer_length, overflowed
//
// A transaction with a segment is stored in states S_LOAD and S_LOAD2,
// since the two endpoints share the single write port of the endpoint
// memory; a transaction without a segment, or whose segment is dropped,
// uses S_LOAD only. After the last transaction of a set, the block runs a
// bottom-up merge sort that ping-pongs between two memories, reading and
// writing each endpoint in S_RD and S_WR on each pass, then a sweep over them.
// The memories need no clearing after reset; only entries below the stored
// count are read. Input is stalled from the last transaction until the result
// is in the output register; a stalled result holds only the next set's end.
module single_layer_coverage_length import slcl_pkg::*; #(
	parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
	parameter int COORD_BITS   = COORD_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	slcl_seg_if.sink  seg,
	slcl_res_if.source res
);

	dp_op_t     op;
	dp_status_t status;

	slcl_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (seg.valid),
		.has_segment  (seg.has_segment),
		.last_segment (seg.last_segment),
		.status       (status),
		.in_ready     (seg.ready),
		.op           (op)
	);

	slcl_datapath #(
		.MAX_SEGMENTS (MAX_SEGMENTS),
		.COORD_BITS   (COORD_BITS)
	) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.op                  (op),
		.left_end            (seg.left_end),
		.right_end           (seg.right_end),
		.out_ready           (res.ready),
		.status              (status),
		.out_valid           (res.valid),
		.single_layer_length (res.single_layer_length),
		.overflowed          (res.overflowed)
	);

`ifndef SYNTHESIS
	// A finished result that is taken is never followed at once by another one.
	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.ready |=> !res.valid)
		else $error("result register reloaded while being taken");

	// The last transaction of a set stops input until the result is produced.
	assert property (@(posedge clk) disable iff (!arst_n)
		seg.valid && seg.ready && seg.last_segment |=> !seg.ready)
		else $error("input accepted right after the last transaction of a set");

	// A new result only appears while input is held off.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res.valid) |-> $past(!seg.ready))
		else $error("result appeared while input was open");
`endif

endmodule
